// ----- hdl/gbfs_pkg.sv -----
// Shared types and constants of the graph traversal core.
package gbfs_pkg;

  localparam int unsigned NODE_W     = 5;
  localparam int unsigned CFG_W      = 6;
  localparam int unsigned LIST_DEPTH = 32;
  localparam int unsigned LIST_AW    = $clog2(LIST_DEPTH);

  localparam logic [CFG_W-1:0] NODE_COUNT_RST = 6'd32;

  // Item kinds; the fourth code is ignored
  localparam logic [1:0] KIND_EDGE   = 2'd0;
  localparam logic [1:0] KIND_BFS    = 2'd1;
  localparam logic [1:0] KIND_DFS    = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
    logic signed [31:0] weight;
    logic [NODE_W-1:0] start_node;
  } gbfs_in_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
    logic              bad_start;
  } gbfs_out_t;

  typedef struct packed {
    logic edge_rd;
    logic edge_wr;
    logic trav_start;
    logic bad_start;
    logic push;
    logic pop;
    logic reload;
    logic finish;
  } gbfs_cmd_t;

  typedef struct packed {
    logic edge_ok;
    logic trav_ok;
    logic start_ok;
    logic cand_any;
    logic list_empty;
    logic out_free;
  } gbfs_status_t;

endpackage

// ----- hdl/gbfs_ctrl.sv -----
// Sequencer of the graph traversal core: edge writes and search steps.
module gbfs_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  gbfs_pkg::gbfs_status_t status_i,
  output gbfs_pkg::gbfs_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_WR,
    ST_SCAN,
    ST_POP,
    ST_FIN
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (status_i.edge_ok) begin
            cmd_o.edge_rd = 1'b1;
            state_d       = ST_EDGE_WR;
          end else if (status_i.trav_ok) begin
            if (status_i.start_ok) begin
              cmd_o.trav_start = 1'b1;
              state_d          = ST_SCAN;
            end else begin
              cmd_o.bad_start = 1'b1;
              state_d         = ST_FIN;
            end
          end
        end
      end
      ST_EDGE_WR: begin
        cmd_o.edge_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_SCAN: begin
        // visit lowest unvisited neighbour, else fetch next row, else finish
        if (status_i.cand_any) begin
          cmd_o.push = status_i.out_free;
        end else if (status_i.list_empty) begin
          state_d = ST_FIN;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP;
        end
      end
      ST_POP: begin
        cmd_o.reload = 1'b1;
        state_d      = ST_SCAN;
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- hdl/gbfs_dp.sv -----
// Datapath of the graph traversal core: adjacency matrix, visited set, work list, result stage.
module gbfs_dp #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gbfs_pkg::gbfs_in_t                  in_data_i,
  input  logic                                cfg_we_i,
  input  logic [gbfs_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  gbfs_pkg::gbfs_cmd_t                 cmd_i,
  output gbfs_pkg::gbfs_status_t              status_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output gbfs_pkg::gbfs_out_t                 out_data_o
);

  localparam int unsigned NW      = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CntW    = gbfs_pkg::CFG_W + 1;
  localparam int unsigned NodeW   = gbfs_pkg::NODE_W;
  localparam int unsigned ListAw  = gbfs_pkg::LIST_AW;
  localparam int unsigned PtrW    = gbfs_pkg::LIST_AW + 1;
  localparam int unsigned ListLen = gbfs_pkg::LIST_DEPTH;

  // Node count register and active range
  logic [gbfs_pkg::CFG_W-1:0] node_count_q;
  logic [CntW-1:0]            n_eff;
  logic [MAX_NODES-1:0]       range_mask;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gbfs_pkg::NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (CntW'(node_count_q) > CntW'(MAX_NODES)) begin
      n_eff = CntW'(MAX_NODES);
    end else begin
      n_eff = CntW'(node_count_q);
    end
    for (int i = 0; i < MAX_NODES; i++) begin
      range_mask[i] = (CntW'(i) < n_eff);
    end
  end

  logic from_ok, to_ok, start_ok;
  assign from_ok  = CntW'(in_data_i.from_node) < n_eff;
  assign to_ok    = CntW'(in_data_i.to_node) < n_eff;
  assign start_ok = CntW'(in_data_i.start_node) < n_eff;

  // Adjacency matrix: one row per source node, rows valid once written
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_vld_q;
  logic [MAX_NODES-1:0] adj_rdata_q;
  logic                 adj_rvld_q;
  logic [MAX_NODES-1:0] row;
  logic [MAX_NODES-1:0] row_new;
  logic [NW-1:0]        adj_raddr;
  logic                 adj_re;

  logic [NW-1:0] from_q;
  logic [NW-1:0] to_q;
  logic          set_q;

  logic [MAX_NODES-1:0] vis_q;
  logic [MAX_NODES-1:0] cand;
  logic [NW-1:0]        y_idx;

  logic [NodeW-1:0] wl_mem [ListLen];
  logic [NodeW-1:0] wl_rdata_q;
  logic [PtrW-1:0]  head_q;
  logic [PtrW-1:0]  tail_q;
  logic [PtrW-1:0]  wl_raddr;
  logic             dfs_q;
  logic [NodeW-1:0] u_q;

  logic [NodeW-1:0]    hold_node_q;
  logic                hold_bad_q;
  gbfs_pkg::gbfs_out_t out_q;
  logic                out_vld_q;
  logic                out_free;

  // Breadth-first keeps scanning the same row after a push; depth-first descends
  assign adj_re = cmd_i.edge_rd | cmd_i.trav_start | (cmd_i.push & dfs_q) | cmd_i.reload;

  always_comb begin
    adj_raddr = '0;
    if (cmd_i.edge_rd) begin
      adj_raddr = NW'(in_data_i.from_node);
    end else if (cmd_i.trav_start) begin
      adj_raddr = NW'(in_data_i.start_node);
    end else if (cmd_i.push) begin
      adj_raddr = y_idx;
    end else if (cmd_i.reload) begin
      adj_raddr = NW'(wl_rdata_q);
    end
  end

  assign row = adj_rvld_q ? adj_rdata_q : '0;

  always_comb begin
    row_new       = row;
    row_new[to_q] = set_q;
  end

  always_ff @(posedge clk_i) begin
    if (adj_re) begin
      adj_rdata_q <= adj_mem[adj_raddr];
    end
    if (cmd_i.edge_wr) begin
      adj_mem[from_q] <= row_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
    end else begin
      if (adj_re) begin
        adj_rvld_q <= adj_vld_q[adj_raddr];
      end
      if (cmd_i.edge_wr) begin
        adj_vld_q[from_q] <= 1'b1;
      end
    end
  end

  // Hold the edge transaction for the read-modify-write of its row
  always_ff @(posedge clk_i) begin
    if (cmd_i.edge_rd) begin
      from_q <= NW'(in_data_i.from_node);
      to_q   <= NW'(in_data_i.to_node);
      set_q  <= (in_data_i.weight != '0) && !in_data_i.weight[31];
    end
  end

  // Unvisited neighbours in range, lowest index first
  assign cand = row & ~vis_q & range_mask;

  always_comb begin
    y_idx = '0;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        y_idx = NW'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q <= '0;
    end else if (cmd_i.trav_start) begin
      vis_q <= MAX_NODES'(1) << NW'(in_data_i.start_node);
    end else if (cmd_i.bad_start) begin
      vis_q <= '0;
    end else if (cmd_i.push) begin
      vis_q[y_idx] <= 1'b1;
    end
  end

  // Work list: FIFO of rows still to scan, or stack of ancestors in depth-first mode
  assign wl_raddr = dfs_q ? (tail_q - PtrW'(1)) : head_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      wl_mem[tail_q[ListAw-1:0]] <= dfs_q ? u_q : NodeW'(y_idx);
    end
    if (cmd_i.pop) begin
      wl_rdata_q <= wl_mem[wl_raddr[ListAw-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      dfs_q  <= 1'b0;
    end else if (cmd_i.trav_start) begin
      head_q <= '0;
      tail_q <= '0;
      dfs_q  <= (in_data_i.kind == gbfs_pkg::KIND_DFS);
    end else if (cmd_i.push) begin
      tail_q <= tail_q + PtrW'(1);
    end else if (cmd_i.pop) begin
      if (dfs_q) begin
        tail_q <= tail_q - PtrW'(1);
      end else begin
        head_q <= head_q + PtrW'(1);
      end
    end
  end

  // Current node whose row is being scanned
  always_ff @(posedge clk_i) begin
    if (cmd_i.trav_start) begin
      u_q <= in_data_i.start_node;
    end else if (cmd_i.push) begin
      u_q <= NodeW'(y_idx);
    end else if (cmd_i.reload) begin
      u_q <= wl_rdata_q;
    end
  end

  // One result is held back until it is known whether another follows
  always_ff @(posedge clk_i) begin
    if (cmd_i.trav_start) begin
      hold_node_q <= in_data_i.start_node;
      hold_bad_q  <= 1'b0;
    end else if (cmd_i.bad_start) begin
      hold_node_q <= '0;
      hold_bad_q  <= 1'b1;
    end else if (cmd_i.push) begin
      hold_node_q <= NodeW'(y_idx);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.node      <= hold_node_q;
      out_q.last      <= 1'b0;
      out_q.bad_start <= 1'b0;
    end else if (cmd_i.finish) begin
      out_q.node      <= hold_node_q;
      out_q.last      <= 1'b1;
      out_q.bad_start <= hold_bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.push || cmd_i.finish) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_free = !out_vld_q || !out_stall_i;

  assign status_o.edge_ok    = (in_data_i.kind == gbfs_pkg::KIND_EDGE) && from_ok && to_ok;
  assign status_o.trav_ok    = (in_data_i.kind == gbfs_pkg::KIND_BFS) ||
                               (in_data_i.kind == gbfs_pkg::KIND_DFS);
  assign status_o.start_ok   = start_ok;
  assign status_o.cand_any   = |cand;
  assign status_o.list_empty = (head_q == tail_q);
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- hdl/graph_bfs_dfs_traversal_core.sv -----
// Directed graph traversal core: adjacency bit matrix with breadth-first and depth-first search.
// An edge transaction sets or clears one matrix entry by a row read and then a row write and
// gives no result. A traversal transaction emits every node reachable from its start node, the
// final one marked last; a start node at or above the node count gives one result flagged
// bad_start. Once a traversal is accepted the core stays busy: it emits each neighbour as it is
// found, and does a work-list read plus a registered adjacency row read each time a row runs
// out of unvisited neighbours, except after the last row, where an empty scan and a closing
// state end it; output stalls add to these steps. Input is taken only between transactions;
// the last result may still wait in the output register.
module graph_bfs_dfs_traversal_core #(
  parameter int unsigned MAX_NODES = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gbfs_pkg::gbfs_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gbfs_pkg::gbfs_out_t         out_data_o,
  input  logic                        cfg_we_i,
  input  logic [gbfs_pkg::CFG_W-1:0]  cfg_wdata_i
);

  gbfs_pkg::gbfs_cmd_t    cmd;
  gbfs_pkg::gbfs_status_t status;

  gbfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  gbfs_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the graph traversal core: random edge writes and BFS/DFS walks.
module tb;

  localparam int unsigned WALK_MAX = 32;
  localparam int unsigned NW       = gbfs_pkg::NODE_W;
  localparam int unsigned CW       = gbfs_pkg::CFG_W;

  class traversal_tracker;
    logic [31:0] adj [WALK_MAX];
    logic [CW-1:0] node_count;
    gbfs_pkg::gbfs_out_t pending_visits[$];
    gbfs_pkg::gbfs_out_t walk_buf[$];
    int errors;
    int visits_seen;

    function new();
      foreach (adj[i]) adj[i] = '0;
      node_count = gbfs_pkg::NODE_COUNT_RST;
      errors = 0;
      visits_seen = 0;
    endfunction

    function int unsigned active_nodes();
      return (node_count > CW'(WALK_MAX)) ? WALK_MAX : 32'(node_count);
    endfunction

    function void visit(logic [NW-1:0] node, logic bad);
      gbfs_pkg::gbfs_out_t v;
      v.node = node;
      v.last = 1'b0;
      v.bad_start = bad;
      walk_buf = {walk_buf, v};
    endfunction

    function void walk_breadth(logic [NW-1:0] start, int unsigned n);
      logic [NW-1:0] fifo[$];
      logic [31:0] seen;
      logic [NW-1:0] u;
      int unsigned queued;
      int y;
      seen = '0;
      seen[start] = 1'b1;
      fifo = {fifo, start};
      queued = 1;
      while (fifo.size() > 0 && walk_buf.size() < WALK_MAX) begin
        u = fifo.pop_front();
        visit(u, 1'b0);
        for (y = 0; y < n; y++) begin
          if (adj[u][y] && !seen[y] && queued < WALK_MAX) begin
            fifo = {fifo, y[NW-1:0]};
            queued++;
            seen[y] = 1'b1;
          end
        end
      end
    endfunction

    // Recursive preorder on an explicit stack; each frame keeps the next neighbour to scan
    function void walk_depth(logic [NW-1:0] start, int unsigned n);
      logic [NW-1:0] frame_node [WALK_MAX];
      int frame_next [WALK_MAX];
      logic [31:0] seen;
      int depth;
      int top;
      int y;
      logic [NW-1:0] u;
      seen = '0;
      seen[start] = 1'b1;
      frame_node[0] = start;
      frame_next[0] = 0;
      depth = 1;
      visit(start, 1'b0);
      while (depth > 0) begin
        top = depth - 1;
        u = frame_node[top];
        y = frame_next[top];
        while (y < n && !(adj[u][y] && !seen[y])) y++;
        if (y >= n || depth >= WALK_MAX || walk_buf.size() >= WALK_MAX) begin
          depth--;
        end else begin
          frame_next[top] = y + 1;
          seen[y] = 1'b1;
          visit(y[NW-1:0], 1'b0);
          frame_node[depth] = y[NW-1:0];
          frame_next[depth] = 0;
          depth++;
        end
      end
    endfunction

    function void note_item(gbfs_pkg::gbfs_in_t it);
      int unsigned n;
      n = active_nodes();
      walk_buf.delete();
      case (it.kind)
        gbfs_pkg::KIND_EDGE: begin
          if (it.from_node < n && it.to_node < n)
            adj[it.from_node][it.to_node] = ($signed(it.weight) > 32'sd0);
        end
        gbfs_pkg::KIND_BFS, gbfs_pkg::KIND_DFS: begin
          if (it.start_node >= n) visit('0, 1'b1);
          else if (it.kind == gbfs_pkg::KIND_BFS) walk_breadth(it.start_node, n);
          else walk_depth(it.start_node, n);
          walk_buf[walk_buf.size()-1].last = 1'b1;
          pending_visits = {pending_visits, walk_buf};
        end
        default: ;
      endcase
    endfunction

    function void check_visit(gbfs_pkg::gbfs_out_t got);
      gbfs_pkg::gbfs_out_t exp_v;
      visits_seen++;
      if (pending_visits.size() == 0) begin
        errors++;
        if (errors <= 20)
          $display("%0t: unexpected visit node %0d last %0b bad_start %0b", $time,
                   got.node, got.last, got.bad_start);
        return;
      end
      exp_v = pending_visits.pop_front();
      if (got.node !== exp_v.node || got.last !== exp_v.last
          || got.bad_start !== exp_v.bad_start) begin
        errors++;
        if (errors <= 20)
          $display("%0t: expected node %0d last %0b bad %0b, got node %0d last %0b bad %0b",
                   $time, exp_v.node, exp_v.last, exp_v.bad_start,
                   got.node, got.last, got.bad_start);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  gbfs_pkg::gbfs_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  gbfs_pkg::gbfs_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CW-1:0] cfg_wdata_i = '0;

  logic quiet = 1'b0;
  logic [CW-1:0] cur_count = gbfs_pkg::NODE_COUNT_RST;
  int items_sent = 0;
  int edges_sent = 0;
  int walks_sent = 0;
  int count_writes = 0;

  traversal_tracker sb = new();

  graph_bfs_dfs_traversal_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(in_data_i);
      if (out_valid_o && !out_stall_i) sb.check_visit(out_data_o);
    end
  end

  // Output back-pressure: short stalls mostly, a long one now and then, none while quiet
  initial begin : stall_gen
    int run_len;
    int hold_len;
    forever begin
      run_len = quiet ? 50 : $urandom_range(1, 12);
      repeat (run_len) @(posedge clk_i);
      if (!quiet) begin
        hold_len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(1, 3);
        out_stall_i <= 1'b1;
        repeat (hold_len) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #8000000;
    $display("graph_bfs_dfs_traversal_core verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  task automatic issue(input logic [1:0] k, input logic [NW-1:0] a,
                       input logic [NW-1:0] b, input logic [31:0] w,
                       input logic [NW-1:0] s);
    gbfs_pkg::gbfs_in_t it;
    int gap;
    it.kind = k;
    it.from_node = a;
    it.to_node = b;
    it.weight = w;
    it.start_node = s;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (k == gbfs_pkg::KIND_EDGE) edges_sent++;
    if (k == gbfs_pkg::KIND_BFS || k == gbfs_pkg::KIND_DFS) walks_sent++;
  endtask

  // Hold input off until every expected visit has come, then let the core go idle
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_visits.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_node_count(input logic [CW-1:0] v);
    settle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.node_count = v;
    cur_count = v;
    count_writes++;
  endtask

  initial begin
    logic [CW-1:0] node_plan [12];
    int unsigned n;
    int phase;
    int density;
    int len;
    int r;
    int effective;
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    logic [NW-1:0] s;
    logic [31:0] w;

    node_plan = '{6'd32, 6'd1, 6'd2, 6'd63, 6'd8, 6'd33, 6'd16, 6'd3,
                  6'd32, 6'd31, 6'd0, 6'd5};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty graph, weight extremes, cycle, self loop, unused kind
    issue(gbfs_pkg::KIND_BFS, 5'd7, 5'd9, $urandom, 5'd0);
    issue(gbfs_pkg::KIND_DFS, 5'd3, 5'd4, $urandom, 5'd31);
    issue(gbfs_pkg::KIND_EDGE, 5'd0, 5'd1, 32'd1, 5'd17);
    issue(gbfs_pkg::KIND_EDGE, 5'd0, 5'd2, 32'h7FFF_FFFF, 5'd30);
    issue(gbfs_pkg::KIND_EDGE, 5'd1, 5'd31, 32'd5, 5'd1);
    issue(gbfs_pkg::KIND_EDGE, 5'd31, 5'd0, 32'd1, 5'd2);
    issue(gbfs_pkg::KIND_EDGE, 5'd2, 5'd3, 32'd0, 5'd3);
    issue(gbfs_pkg::KIND_EDGE, 5'd2, 5'd3, 32'hFFFF_FFFF, 5'd4);
    issue(gbfs_pkg::KIND_EDGE, 5'd5, 5'd5, 32'd1, 5'd5);
    issue(gbfs_pkg::KIND_UNUSED, 5'd31, 5'd31, 32'd9, 5'd31);
    issue(gbfs_pkg::KIND_BFS, 5'd0, 5'd0, $urandom, 5'd0);
    issue(gbfs_pkg::KIND_DFS, 5'd31, 5'd31, $urandom, 5'd0);
    issue(gbfs_pkg::KIND_DFS, 5'd0, 5'd0, $urandom, 5'd5);
    issue(gbfs_pkg::KIND_EDGE, 5'd0, 5'd1, 32'h8000_0000, 5'd0);
    issue(gbfs_pkg::KIND_BFS, 5'd0, 5'd0, $urandom, 5'd1);
    // Shrunk count: out-of-range edges dropped, bad starts, node 31 kept but not followed
    set_node_count(6'd4);
    issue(gbfs_pkg::KIND_EDGE, 5'd4, 5'd0, 32'd1, 5'd0);
    issue(gbfs_pkg::KIND_EDGE, 5'd0, 5'd31, 32'hFFFF_FFFB, 5'd0);
    issue(gbfs_pkg::KIND_BFS, 5'd0, 5'd0, $urandom, 5'd4);
    issue(gbfs_pkg::KIND_DFS, 5'd0, 5'd0, $urandom, 5'd31);
    issue(gbfs_pkg::KIND_DFS, 5'd0, 5'd0, $urandom, 5'd1);
    issue(gbfs_pkg::KIND_BFS, 5'd0, 5'd0, $urandom, 5'd0);
    set_node_count(6'd0);
    issue(gbfs_pkg::KIND_EDGE, 5'd0, 5'd0, 32'd1, 5'd0);
    issue(gbfs_pkg::KIND_DFS, 5'd0, 5'd0, $urandom, 5'd0);
    set_node_count(6'd63);
    issue(gbfs_pkg::KIND_BFS, 5'd0, 5'd0, $urandom, 5'd0);
    issue(gbfs_pkg::KIND_DFS, 5'd0, 5'd0, $urandom, 5'd31);

    // Random phases, each under its own node count and edge density
    effective = 0;
    phase = 0;
    while (effective < 300) begin
      if (phase < 12) set_node_count(node_plan[phase]);
      else set_node_count(($urandom_range(0, 2) == 0) ? 6'd32 : 6'($urandom_range(1, 63)));
      quiet = ($urandom_range(0, 3) == 0);
      density = $urandom_range(30, 95);
      len = $urandom_range(15, 40);
      n = (cur_count > CW'(WALK_MAX)) ? WALK_MAX : 32'(cur_count);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 3) settle();
        a = (n > 0 && $urandom_range(0, 99) < 90) ? NW'($urandom_range(0, n - 1))
                                                   : NW'($urandom_range(0, 31));
        b = (n > 0 && $urandom_range(0, 99) < 90) ? NW'($urandom_range(0, n - 1))
                                                   : NW'($urandom_range(0, 31));
        s = (n > 0 && $urandom_range(0, 99) < 88) ? NW'($urandom_range(0, n - 1))
                                                   : NW'($urandom_range(0, 31));
        if ($urandom_range(0, 99) < density) begin
          w = $urandom & 32'h7FFF_FFFF;
          if (w == 0) w = 32'd1;
        end else begin
          case ($urandom_range(0, 3))
            0: w = 32'd0;
            1: w = 32'h8000_0000;
            default: w = $urandom | 32'h8000_0000;
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
          issue(gbfs_pkg::KIND_EDGE, a, b, w, s);
          if (a < n && b < n) effective++;
        end else if (r < 95) begin
          issue((r < 75) ? gbfs_pkg::KIND_BFS : gbfs_pkg::KIND_DFS, a, b, w, s);
          effective++;
        end else begin
          issue(gbfs_pkg::KIND_UNUSED, a, b, w, s);
        end
      end
      phase++;
    end

    quiet = 1'b0;
    settle();
    $display("Run covered %0d transactions (%0d edge writes, %0d walks), %0d count settings,",
             items_sent, edges_sent, walks_sent, count_writes);
    $display("and checked %0d visits against the predicted order.", sb.visits_seen);
    if (sb.errors == 0 && sb.pending_visits.size() == 0) begin
      $display("graph_bfs_dfs_traversal_core verification clean");
    end else begin
      $display("graph_bfs_dfs_traversal_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/gbfs_pkg.sv
hdl/gbfs_ctrl.sv
hdl/gbfs_dp.sv
hdl/graph_bfs_dfs_traversal_core.sv
sim/tb.sv
